[design/bm3_pkg.sv]
// Package with the item types, register codes and fixed widths of the 3x3 morphology block.
`timescale 1ns / 1ps

package bm3_pkg;

    localparam int PIX_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W = 9;
    localparam int SIZE_W = 10;
    localparam int MODE_W = 2;
    localparam int MAJ_COUNT = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_FG     = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_DILATE   = 2'd0,
        MODE_ERODE    = 2'd1,
        MODE_MAJORITY = 2'd2
    } t_mode;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             frame_first;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] out_value;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_last;
    } t_out_item;

    typedef struct packed {
        logic             emit;
        logic             interior;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_stage;

endpackage

[design/binary_morphology_3x3.sv]
// Two register stages: the first stage register in bm3_ctrl and the output register in
// bm3_filter. Throughput: one item per cycle while the output is not stalled.
// The line store RAM takes one read and one write per cycle.
// The only stall comes from the output side through a single output register.
// Reset clears the counters, window registers, pipeline valids and the configuration
// to its defaults; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module binary_morphology_3x3 #(
    parameter int MAX_WIDTH = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bm3_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bm3_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bm3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bm3_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [bm3_pkg::MODE_W-1:0] r_mode;
    logic [bm3_pkg::PIX_W-1:0]  r_fg_value;
    logic [bm3_pkg::SIZE_W-1:0] r_img_width;
    logic [bm3_pkg::SIZE_W-1:0] r_img_height;

    logic                        go, accept, s1_valid, wr_en;
    logic [CW-1:0]               rd_addr, s1_addr, wr_addr;
    bm3_pkg::t_stage             s1;
    logic [2*bm3_pkg::PIX_W-1:0] rd_data, wr_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bm3_pkg::MODE_DILATE;
            r_fg_value <= 16'hFFFF;
            r_img_width <= 10'd320;
            r_img_height <= 10'd240;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (bm3_pkg::t_cfg_idx'(i_cfg_index))
                bm3_pkg::CFG_MODE:   r_mode <= i_cfg_data[bm3_pkg::MODE_W-1:0];
                bm3_pkg::CFG_FG:     r_fg_value <= i_cfg_data;
                bm3_pkg::CFG_WIDTH:  r_img_width <= i_cfg_data[bm3_pkg::SIZE_W-1:0];
                bm3_pkg::CFG_HEIGHT: r_img_height <= i_cfg_data[bm3_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bm3_ctrl #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_item(i_in_item),
        .i_go(go),
        .i_img_width(r_img_width),
        .i_img_height(r_img_height),
        .o_in_stall(o_in_stall),
        .o_accept(accept),
        .o_rd_addr(rd_addr),
        .o_s1_valid(s1_valid),
        .o_s1(s1),
        .o_s1_addr(s1_addr)
    );

    bm3_ram #(
        .WIDTH(2 * bm3_pkg::PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk(i_clk),
        .i_wr_en(wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en(accept),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    bm3_filter #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_filter (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s1_valid(s1_valid),
        .i_s1(s1),
        .i_s1_addr(s1_addr),
        .i_accept(accept),
        .i_rd_addr(rd_addr),
        .i_rd_data(rd_data),
        .i_mode(r_mode),
        .i_fg_value(r_fg_value),
        .i_out_stall(i_out_stall),
        .o_go(go),
        .o_wr_en(wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data),
        .o_out_valid(o_out_valid),
        .o_out_item(o_out_item)
    );

endmodule

[design/bm3_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/bm3_ctrl.sv]
// Raster counters, border and position logic, and the first pipeline stage register.
`timescale 1ns / 1ps

module bm3_ctrl #(
    parameter int MAX_WIDTH = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  bm3_pkg::t_in_item            i_in_item,
    input  logic                         i_go,
    input  logic [bm3_pkg::SIZE_W-1:0]   i_img_width,
    input  logic [bm3_pkg::SIZE_W-1:0]   i_img_height,
    output logic                         o_in_stall,
    output logic                         o_accept,
    output logic [$clog2(MAX_WIDTH)-1:0] o_rd_addr,
    output logic                         o_s1_valid,
    output bm3_pkg::t_stage              o_s1,
    output logic [$clog2(MAX_WIDTH)-1:0] o_s1_addr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = (CW > RW) ? CW : RW;
    localparam int SW = ((DW > bm3_pkg::SIZE_W) ? DW : bm3_pkg::SIZE_W) + 2;

    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic            r_s1_valid, n_s1_valid;
    bm3_pkg::t_stage r_s1, n_s1;
    logic [CW-1:0]   r_s1_addr;

    logic [SW-1:0] w, h, c0, r0, pr, pc, cn, rn;
    logic          emit, interior, last;

    always_comb begin
        if ({{(SW-bm3_pkg::SIZE_W){1'b0}}, i_img_width} < SW'(3)) begin
            w = SW'(3);
        end else if ({{(SW-bm3_pkg::SIZE_W){1'b0}}, i_img_width} > SW'(MAX_WIDTH)) begin
            w = SW'(MAX_WIDTH);
        end else begin
            w = {{(SW-bm3_pkg::SIZE_W){1'b0}}, i_img_width};
        end
        if ({{(SW-bm3_pkg::SIZE_W){1'b0}}, i_img_height} < SW'(3)) begin
            h = SW'(3);
        end else if ({{(SW-bm3_pkg::SIZE_W){1'b0}}, i_img_height} > SW'(MAX_HEIGHT)) begin
            h = SW'(MAX_HEIGHT);
        end else begin
            h = {{(SW-bm3_pkg::SIZE_W){1'b0}}, i_img_height};
        end
    end

    always_comb begin
        c0 = i_in_item.frame_first ? '0 : {{(SW-CW){1'b0}}, r_col};
        r0 = i_in_item.frame_first ? '0 : {{(SW-RW){1'b0}}, r_row};
        emit = (r0 >= SW'(2)) || ((r0 == SW'(1)) && (c0 >= SW'(1)));
        if (c0 >= SW'(1)) begin
            pr = r0 - SW'(1);
            pc = c0 - SW'(1);
        end else begin
            pr = r0 - SW'(2);
            pc = w - SW'(1);
        end
        interior = (pr >= SW'(1)) && (pr + SW'(2) <= h)
                && (pc >= SW'(1)) && (pc + SW'(2) <= w);
        last = (r0 + SW'(1) == h) && (c0 + SW'(1) == w);
        cn = c0 + SW'(1);
        rn = r0;
        if (cn >= w) begin
            cn = '0;
            rn = r0 + SW'(1);
            if (rn >= h) begin
                rn = '0;
            end
        end
    end

    assign o_in_stall = r_s1_valid && !i_go;
    assign o_accept = i_in_valid && !o_in_stall;
    assign o_rd_addr = c0[CW-1:0];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_s1 = r_s1;
        n_s1_valid = r_s1_valid;
        if (o_accept) begin
            n_col = cn[CW-1:0];
            n_row = rn[RW-1:0];
            n_s1_valid = 1'b1;
            n_s1.emit = emit;
            n_s1.interior = interior;
            n_s1.last = last;
            n_s1.row = pr[bm3_pkg::POS_W-1:0];
            n_s1.col = pc[bm3_pkg::POS_W-1:0];
            n_s1.pix = i_in_item.pixel_value;
        end else if (i_go) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        if (o_accept) begin
            r_s1_addr <= o_rd_addr;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1 = r_s1;
    assign o_s1_addr = r_s1_addr;

endmodule

[design/bm3_filter.sv]
// Window registers, line store write-back with forwarding, 3x3 filter and output register.
`timescale 1ns / 1ps

module bm3_filter #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s1_valid,
    input  bm3_pkg::t_stage               i_s1,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_s1_addr,
    input  logic                          i_accept,
    input  logic [$clog2(MAX_WIDTH)-1:0]  i_rd_addr,
    input  logic [2*bm3_pkg::PIX_W-1:0]   i_rd_data,
    input  logic [bm3_pkg::MODE_W-1:0]    i_mode,
    input  logic [bm3_pkg::PIX_W-1:0]     i_fg_value,
    input  logic                          i_out_stall,
    output logic                          o_go,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0]  o_wr_addr,
    output logic [2*bm3_pkg::PIX_W-1:0]   o_wr_data,
    output logic                          o_out_valid,
    output bm3_pkg::t_out_item            o_out_item
);

    localparam int PW = bm3_pkg::PIX_W;
    localparam int SUM_W = PW + 4;

    logic [PW-1:0]      r_win [6];
    logic               r_fwd;
    logic [2*PW-1:0]    r_fwd_data;
    logic               r_out_valid, n_out_valid;
    bm3_pkg::t_out_item r_out, n_out;

    logic [2*PW-1:0] lines;
    logic [PW-1:0]   top, mid;
    logic [PW-1:0]   win [9];
    logic            adv, any_fg, any_zero;
    logic [SUM_W-1:0] sum, thresh;
    logic [PW-1:0]   filt;

    assign o_go = !r_out_valid || !i_out_stall;
    assign adv = i_s1_valid && o_go;

    assign lines = r_fwd ? r_fwd_data : i_rd_data;
    assign top = lines[2*PW-1:PW];
    assign mid = lines[PW-1:0];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            win[i] = r_win[i];
        end
        win[6] = top;
        win[7] = mid;
        win[8] = i_s1.pix;
        any_fg = 1'b0;
        any_zero = 1'b0;
        for (int i = 0; i < 9; i++) begin
            any_fg = any_fg | (win[i] == i_fg_value);
            any_zero = any_zero | (win[i] == '0);
        end
        sum = '0;
        for (int i = 0; i < 9; i++) begin
            sum = sum + {{(SUM_W-PW){1'b0}}, win[i]};
        end
        thresh = SUM_W'(bm3_pkg::MAJ_COUNT) * {{(SUM_W-PW){1'b0}}, i_fg_value};
        case (i_mode)
            bm3_pkg::MODE_DILATE: filt = any_fg ? i_fg_value : '0;
            bm3_pkg::MODE_ERODE:  filt = any_zero ? '0 : i_fg_value;
            default:              filt = (sum >= thresh) ? i_fg_value : '0;
        endcase
    end

    assign o_wr_en = adv;
    assign o_wr_addr = i_s1_addr;
    assign o_wr_data = {mid, i_s1.pix};

    always_comb begin
        n_out = r_out;
        n_out_valid = r_out_valid;
        if (adv && i_s1.emit) begin
            n_out_valid = 1'b1;
            n_out.out_value = i_s1.interior ? filt : '0;
            n_out.out_row = i_s1.row;
            n_out.out_col = i_s1.col;
            n_out.frame_last = i_s1.last;
        end else if (o_go) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
            r_fwd <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= i_s1.pix;
            end
            if (i_accept) begin
                r_fwd <= adv && (i_s1_addr == i_rd_addr);
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_fwd_data <= {mid, i_s1.pix};
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

endmodule

[dv/binary_morphology_3x3_test.sv]
// Self-checking testbench of the 3x3 binary morphology filter, with its own window model.
`timescale 1ns / 1ps

module binary_morphology_3x3_test;

    localparam int MAX_W = 512;
    localparam int MAX_H = 512;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PIXELS = 450;
    localparam int REPORT_LIMIT = 10;
    localparam logic [bm3_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    logic clk;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_stall;
    bm3_pkg::t_in_item pix_in = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    bm3_pkg::t_out_item res_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bm3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic [bm3_pkg::MODE_W-1:0] cur_mode = bm3_pkg::MODE_DILATE;
    logic [bm3_pkg::PIX_W-1:0] cur_fg = 16'hFFFF;
    logic [bm3_pkg::SIZE_W-1:0] cur_width = 10'd320;
    logic [bm3_pkg::SIZE_W-1:0] cur_height = 10'd240;
    logic [bm3_pkg::PIX_W-1:0] rows_above [2][MAX_W] = '{default: '0};
    logic [bm3_pkg::PIX_W-1:0] window [6] = '{default: '0};
    int unsigned row_ctr = 0;
    int unsigned col_ctr = 0;
    bm3_pkg::t_out_item filtered_pixels [$];

    int bad_pixels = 0;
    int pixels_sent = 0;
    int unsigned cycle_count = 0;
    int hold_off = 0;
    int stall_left = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;

    binary_morphology_3x3 #(
        .MAX_WIDTH(MAX_W),
        .MAX_HEIGHT(MAX_H)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(pix_valid),
        .o_in_stall(pix_stall),
        .i_in_item(pix_in),
        .o_out_valid(res_valid),
        .i_out_stall(res_stall),
        .o_out_item(res_out),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int pause_length();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [bm3_pkg::PIX_W-1:0] pick_pixel();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return cur_fg;
        if (pick < 85) return '0;
        return bm3_pkg::PIX_W'($urandom);
    endfunction

    function automatic logic [bm3_pkg::SIZE_W-1:0] random_size();
        if ($urandom_range(0, 9) == 0) return bm3_pkg::SIZE_W'($urandom_range(0, 2));
        return bm3_pkg::SIZE_W'($urandom_range(3, 12));
    endfunction

    // Advances the window model by one pixel and queues the filtered pixel it releases.
    task automatic filter_window_step(input bm3_pkg::t_in_item it);
        int unsigned w, h, r, c, col, out_r, out_c, total;
        logic [bm3_pkg::PIX_W-1:0] upper, middle, value;
        logic [bm3_pkg::PIX_W-1:0] taps [9];
        logic hit_fg, hit_zero;
        bm3_pkg::t_out_item due;
        w = clamp_size(cur_width, MAX_W);
        h = clamp_size(cur_height, MAX_H);
        if (it.frame_first) begin
            row_ctr = 0;
            col_ctr = 0;
        end
        r = row_ctr;
        c = col_ctr;
        col = (c < MAX_W) ? c : MAX_W - 1;
        upper = rows_above[1][col];
        middle = rows_above[0][col];
        for (int i = 0; i < 6; i++) taps[i] = window[i];
        taps[6] = upper;
        taps[7] = middle;
        taps[8] = it.pixel_value;
        if (r >= 2 || (r == 1 && c >= 1)) begin
            if (c >= 1) begin
                out_r = r - 1;
                out_c = c - 1;
            end else begin
                out_r = r - 2;
                out_c = w - 1;
            end
            value = '0;
            if (out_r >= 1 && out_r + 2 <= h && out_c >= 1 && out_c + 2 <= w) begin
                hit_fg = 1'b0;
                hit_zero = 1'b0;
                total = 0;
                foreach (taps[i]) begin
                    if (taps[i] == cur_fg) hit_fg = 1'b1;
                    if (taps[i] == '0) hit_zero = 1'b1;
                    total += taps[i];
                end
                case (cur_mode)
                    bm3_pkg::MODE_DILATE: value = hit_fg ? cur_fg : '0;
                    bm3_pkg::MODE_ERODE: value = hit_zero ? '0 : cur_fg;
                    default: value = (total >= bm3_pkg::MAJ_COUNT * cur_fg) ? cur_fg : '0;
                endcase
            end
            due.out_value = value;
            due.out_row = out_r[bm3_pkg::POS_W-1:0];
            due.out_col = out_c[bm3_pkg::POS_W-1:0];
            due.frame_last = (r + 1 == h && c + 1 == w);
            filtered_pixels.push_back(due);
        end
        rows_above[1][col] = middle;
        rows_above[0][col] = it.pixel_value;
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = upper;
        window[4] = middle;
        window[5] = it.pixel_value;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_ctr = r;
        col_ctr = c;
    endtask

    task automatic send_pixel(input bm3_pkg::t_in_item it);
        int gap;
        gap = (sender_idles && $urandom_range(0, 99) < 30) ? pause_length() : 0;
        repeat (gap) begin
            @(negedge clk);
            pix_valid <= 1'b0;
        end
        @(negedge clk);
        pix_valid <= 1'b1;
        pix_in <= it;
        do @(posedge clk); while (pix_stall);
        filter_window_step(it);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int count, input bit first, input bit noisy);
        bm3_pkg::t_in_item it;
        for (int k = 0; k < count; k++) begin
            it.pixel_value = pick_pixel();
            it.frame_first = (k == 0) ? first : (noisy && $urandom_range(0, 149) == 0);
            send_pixel(it);
        end
    endtask

    task automatic send_mask(input logic [8:0] mask, input logic [bm3_pkg::PIX_W-1:0] on,
                             input logic [bm3_pkg::PIX_W-1:0] off);
        bm3_pkg::t_in_item it;
        for (int k = 0; k < 9; k++) begin
            it.pixel_value = mask[8 - k] ? on : off;
            it.frame_first = (k == 0);
            send_pixel(it);
        end
    endtask

    task automatic write_register(input bm3_pkg::t_cfg_idx idx,
                                  input logic [bm3_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            bm3_pkg::CFG_MODE: cur_mode = value[bm3_pkg::MODE_W-1:0];
            bm3_pkg::CFG_FG: cur_fg = value;
            bm3_pkg::CFG_WIDTH: cur_width = value[bm3_pkg::SIZE_W-1:0];
            bm3_pkg::CFG_HEIGHT: cur_height = value[bm3_pkg::SIZE_W-1:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering pixels and waits until the filter has nothing left in flight.
    task automatic settle();
        @(negedge clk);
        pix_valid <= 1'b0;
        while (filtered_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Unused upper data bits are filled with noise; the block must ignore them.
    task automatic set_filter(input logic [bm3_pkg::MODE_W-1:0] m,
                              input logic [bm3_pkg::PIX_W-1:0] fg,
                              input logic [bm3_pkg::SIZE_W-1:0] w,
                              input logic [bm3_pkg::SIZE_W-1:0] h);
        settle();
        write_register(bm3_pkg::CFG_MODE,
                       {(bm3_pkg::CFG_DATA_W - bm3_pkg::MODE_W)'($urandom), m});
        write_register(bm3_pkg::CFG_FG, fg);
        write_register(bm3_pkg::CFG_WIDTH,
                       {(bm3_pkg::CFG_DATA_W - bm3_pkg::SIZE_W)'($urandom), w});
        write_register(bm3_pkg::CFG_HEIGHT,
                       {(bm3_pkg::CFG_DATA_W - bm3_pkg::SIZE_W)'($urandom), h});
    endtask

    // The first frame spans the widest row used later, so every line store entry read
    // afterwards has been written.
    task automatic test_widest_frame();
        set_filter(bm3_pkg::MODE_DILATE, 16'hFFFF, 10'd16, 10'd3);
        send_pixels(16 * 3, 1'b1, 1'b0);
    endtask

    task automatic test_each_operation();
        set_filter(bm3_pkg::MODE_DILATE, 16'hFFFF, 10'd3, 10'd3);
        send_mask(9'b000_010_000, 16'hFFFF, 16'h0000);
        set_filter(bm3_pkg::MODE_ERODE, 16'h5A5A, 10'd3, 10'd3);
        send_mask(9'b000_000_000, 16'h5A5A, 16'h0001);
        set_filter(bm3_pkg::MODE_MAJORITY, 16'hFFFF, 10'd3, 10'd3);
        send_mask(9'b101_010_101, 16'hFFFF, 16'h0000);
        set_filter(MODE_SPARE, 16'hFFFF, 10'd3, 10'd3);
        send_mask(9'b100_010_101, 16'hFFFF, 16'h0001);
    endtask

    task automatic test_tallest_frame();
        set_filter(bm3_pkg::MODE_MAJORITY, 16'h8000, 10'd3, 10'd1023);
        send_pixels(3 * 15, 1'b1, 1'b0);
    endtask

    // The sizes change in the middle of a row of a running frame, the first change leaving the counters beyond them.
    task automatic test_shrink_mid_frame();
        set_filter(bm3_pkg::MODE_MAJORITY, bm3_pkg::PIX_W'($urandom), 10'd10, 10'd6);
        send_pixels(37, 1'b1, 1'b0);
        set_filter(bm3_pkg::MODE_ERODE, cur_fg, 10'd5, 10'd3);
        send_pixels(40, 1'b0, 1'b0);
        set_filter(bm3_pkg::MODE_DILATE, cur_fg, 10'd9, 10'd7);
        send_pixels(30, 1'b0, 1'b0);
    endtask

    task automatic test_output_backpressure();
        set_filter(bm3_pkg::MODE_ERODE, 16'h00FF, 10'd6, 10'd5);
        sender_idles = 1'b0;
        hold_off = 150;
        send_pixels(60, 1'b1, 1'b0);
        sender_idles = 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned w, h, frames, count;
        int stop_at;
        logic [bm3_pkg::PIX_W-1:0] fg;
        stop_at = pixels_sent + RANDOM_PIXELS;
        while (pixels_sent < stop_at) begin
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0: fg = '0;
                1: fg = '1;
                2: fg = bm3_pkg::PIX_W'($urandom_range(1, 8));
                default: fg = bm3_pkg::PIX_W'($urandom);
            endcase
            set_filter(bm3_pkg::MODE_W'($urandom_range(0, 3)), fg, random_size(),
                       random_size());
            w = clamp_size(cur_width, MAX_W);
            h = clamp_size(cur_height, MAX_H);
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                count = w * h;
                if (f == frames - 1 && $urandom_range(0, 1) == 1) begin
                    count = $urandom_range(1, count);
                end
                send_pixels(count, $urandom_range(0, 3) != 0, 1'b1);
            end
        end
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial begin
        forever begin
            @(negedge clk);
            if (hold_off > 0) begin
                res_stall <= 1'b1;
                hold_off--;
            end else if (stall_left > 0) begin
                res_stall <= 1'b1;
                stall_left--;
            end else if (receiver_idles && $urandom_range(0, 99) < 25) begin
                res_stall <= 1'b1;
                stall_left = pause_length() - 1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        bm3_pkg::t_out_item due;
        if (rst_n && res_valid && !res_stall) begin
            if (filtered_pixels.size() == 0) begin
                bad_pixels++;
                if (bad_pixels <= REPORT_LIMIT) begin
                    $display("unexpected item: row %0d col %0d value %h last %b",
                             res_out.out_row, res_out.out_col, res_out.out_value,
                             res_out.frame_last);
                end
            end else begin
                due = filtered_pixels.pop_front();
                if (res_out.out_value !== due.out_value || res_out.out_row !== due.out_row
                        || res_out.out_col !== due.out_col
                        || res_out.frame_last !== due.frame_last) begin
                    bad_pixels++;
                    if (bad_pixels <= REPORT_LIMIT) begin
                        $display("mismatch: got row %0d col %0d value %h last %b, %s",
                                 res_out.out_row, res_out.out_col, res_out.out_value,
                                 res_out.frame_last,
                                 $sformatf("wanted row %0d col %0d value %h last %b",
                                           due.out_row, due.out_col, due.out_value,
                                           due.frame_last));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binary_morphology_3x3_test: errors");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_widest_frame();
        test_each_operation();
        test_tallest_frame();
        test_shrink_mid_frame();
        test_output_backpressure();
        test_random_frames();
        settle();
        if (bad_pixels == 0) begin
            $display("binary_morphology_3x3_test: clean");
        end else begin
            $display("binary_morphology_3x3_test: errors");
        end
        $finish;
    end

endmodule

[files.f]
design/bm3_pkg.sv
design/bm3_ram.sv
design/bm3_ctrl.sv
design/bm3_filter.sv
design/binary_morphology_3x3.sv
dv/binary_morphology_3x3_test.sv
